### design/msps_pkg.sv
// Shared types and constants for the matrix saddle point search block.
package msps_pkg;

	localparam int MAX_ROWS_DEF = 8;
	localparam int MAX_COLS_DEF = 8;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;

	localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic             load;
		logic             first_row;
		logic             first_col;
		logic [IDX_W-1:0] load_row;
		logic [IDX_W-1:0] load_col;
		logic             scan;
		logic [IDX_W-1:0] scan_row;
		logic [IDX_W-1:0] scan_col;
		logic             flush;
	} cmd_t;

	typedef struct packed {
		logic scan_stall;
		logic out_free;
	} stat_t;

endpackage

### design/msps_ctrl.sv
// Controller: configuration registers, load and scan sequencing.
module msps_ctrl #(
	parameter int MAX_ROWS = msps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = msps_pkg::MAX_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [msps_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	output msps_pkg::cmd_t              cmd,
	input  msps_pkg::stat_t             stat
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [msps_pkg::CNT_W-1:0] ROWS_MAX = msps_pkg::CNT_W'(MAX_ROWS);
	localparam logic [msps_pkg::CNT_W-1:0] COLS_MAX = msps_pkg::CNT_W'(MAX_COLS);

	logic [1:0]                  state_q;
	logic [msps_pkg::CNT_W-1:0]  row_cnt_q, col_cnt_q;
	logic [msps_pkg::CNT_W-1:0]  rows_eff, cols_eff;
	logic [msps_pkg::IDX_W-1:0]  load_row_q, load_col_q, scan_row_q, scan_col_q;
	logic                        accept, load_col_end, load_row_end, scan_col_end, scan_row_end;

	always_comb begin
		if (row_cnt_q == '0) begin
			rows_eff = msps_pkg::CNT_W'(1);
		end else if (row_cnt_q > ROWS_MAX) begin
			rows_eff = ROWS_MAX;
		end else begin
			rows_eff = row_cnt_q;
		end
		if (col_cnt_q == '0) begin
			cols_eff = msps_pkg::CNT_W'(1);
		end else if (col_cnt_q > COLS_MAX) begin
			cols_eff = COLS_MAX;
		end else begin
			cols_eff = col_cnt_q;
		end
	end

	assign in_ready     = (state_q == ST_LOAD);
	assign accept       = in_valid && in_ready;
	assign load_col_end = ({1'b0, load_col_q} + msps_pkg::CNT_W'(1)) == cols_eff;
	assign load_row_end = ({1'b0, load_row_q} + msps_pkg::CNT_W'(1)) == rows_eff;
	assign scan_col_end = ({1'b0, scan_col_q} + msps_pkg::CNT_W'(1)) == cols_eff;
	assign scan_row_end = ({1'b0, scan_row_q} + msps_pkg::CNT_W'(1)) == rows_eff;

	always_comb begin
		cmd.load      = accept;
		cmd.first_row = (load_row_q == '0);
		cmd.first_col = (load_col_q == '0);
		cmd.load_row  = load_row_q;
		cmd.load_col  = load_col_q;
		cmd.scan      = (state_q == ST_SCAN);
		cmd.scan_row  = scan_row_q;
		cmd.scan_col  = scan_col_q;
		cmd.flush     = (state_q == ST_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			row_cnt_q  <= msps_pkg::CNT_RESET;
			col_cnt_q  <= msps_pkg::CNT_RESET;
			load_row_q <= '0;
			load_col_q <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msps_pkg::REG_ROW_COUNT: row_cnt_q <= cfg_data;
				msps_pkg::REG_COL_COUNT: col_cnt_q <= cfg_data;
				default: ;
			endcase
			load_row_q <= '0;
			load_col_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (load_col_end) begin
							load_col_q <= '0;
							if (load_row_end) begin
								load_row_q <= '0;
								scan_row_q <= '0;
								scan_col_q <= '0;
								state_q    <= ST_SCAN;
							end else begin
								load_row_q <= load_row_q + 1'b1;
							end
						end else begin
							load_col_q <= load_col_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (!stat.scan_stall) begin
						if (scan_col_end) begin
							scan_col_q <= '0;
							if (scan_row_end) begin
								state_q <= ST_FLUSH;
							end else begin
								scan_row_q <= scan_row_q + 1'b1;
							end
						end else begin
							scan_col_q <= scan_col_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (stat.out_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

### design/msps_dp.sv
// Datapath: row minima, column maxima, match compare and result register.
module msps_dp #(
	parameter int MAX_ROWS = msps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = msps_pkg::MAX_COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msps_pkg::cmd_t                     cmd,
	output msps_pkg::stat_t                    stat,
	input  logic signed [msps_pkg::DATA_W-1:0] element_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic signed [msps_pkg::DATA_W-1:0] point_value,
	output logic [msps_pkg::IDX_W-1:0]         row_index,
	output logic [msps_pkg::IDX_W-1:0]         col_index,
	output logic                               last_result
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic signed [msps_pkg::DATA_W-1:0] rmin_q [MAX_ROWS];
	logic signed [msps_pkg::DATA_W-1:0] cmax_q [MAX_COLS];
	logic [RW-1:0]                      ridx;
	logic [CW-1:0]                      cidx;
	logic signed [msps_pkg::DATA_W-1:0] rmin_rd, cmax_rd;
	logic                               match, out_free, push, fin, take;

	logic                               pend_v_q;
	logic signed [msps_pkg::DATA_W-1:0] pend_val_q;
	logic [msps_pkg::IDX_W-1:0]         pend_row_q, pend_col_q;

	logic                               out_v_q, found_q, last_q;
	logic signed [msps_pkg::DATA_W-1:0] val_q;
	logic [msps_pkg::IDX_W-1:0]         row_q, col_q;

	assign ridx    = cmd.load ? cmd.load_row[RW-1:0] : cmd.scan_row[RW-1:0];
	assign cidx    = cmd.load ? cmd.load_col[CW-1:0] : cmd.scan_col[CW-1:0];
	assign rmin_rd = rmin_q[ridx];
	assign cmax_rd = cmax_q[cidx];
	assign match   = (rmin_rd == cmax_rd);

	assign out_free = !out_v_q || out_ready;
	assign push     = cmd.scan && match && pend_v_q && out_free;
	assign fin      = cmd.flush && out_free;
	assign take     = cmd.scan && match && (!pend_v_q || out_free);

	assign stat.scan_stall = cmd.scan && match && pend_v_q && !out_free;
	assign stat.out_free   = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.first_col || (element_value < rmin_rd)) begin
				rmin_q[ridx] <= element_value;
			end
			if (cmd.first_row || (element_value > cmax_rd)) begin
				cmax_q[cidx] <= element_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (take) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
			if (push || fin) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_val_q <= rmin_rd;
			pend_row_q <= cmd.scan_row;
			pend_col_q <= cmd.scan_col;
		end
		if (push) begin
			found_q <= 1'b1;
			val_q   <= pend_val_q;
			row_q   <= pend_row_q;
			col_q   <= pend_col_q;
			last_q  <= 1'b0;
		end else if (fin) begin
			found_q <= pend_v_q;
			val_q   <= pend_v_q ? pend_val_q : '0;
			row_q   <= pend_v_q ? pend_row_q : '0;
			col_q   <= pend_v_q ? pend_col_q : '0;
			last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_v_q;
	assign found       = found_q;
	assign point_value = val_q;
	assign row_index   = row_q;
	assign col_index   = col_q;
	assign last_result = last_q;

endmodule

### design/matrix_saddle_point_search.sv
// Top level of the matrix saddle point search block.
// Usage:
//   Configure row_count (index 0) and col_count (index 1) through cfg_we,
//   cfg_index and cfg_data while the block is idle; each write restarts the
//   matrix load. A count of zero acts as one, a count above the maximum as
//   the maximum.
//   Send elements row-major on in_valid/in_ready, one request per cycle while
//   loading. After the final element in_ready drops while the block scans
//   every row/column pair, one pair per cycle unless the output stalls it;
//   a flush ends the run when the output is free, then in_ready returns.
//   Each saddle point leaves on out_valid/out_ready with found set; the last
//   carries last_result. With none, one request with found clear and
//   last_result set is sent. A held result register plus one pending match
//   register let the scan run on while a result waits; a second match while
//   both are full stalls the scan until out_ready.
//   Reset sets both counts to 8, clears the load position and drops
//   out_valid.
module matrix_saddle_point_search #(
	parameter int MAX_ROWS = msps_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = msps_pkg::MAX_COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [msps_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [msps_pkg::DATA_W-1:0] element_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic signed [msps_pkg::DATA_W-1:0] point_value,
	output logic [msps_pkg::IDX_W-1:0]         row_index,
	output logic [msps_pkg::IDX_W-1:0]         col_index,
	output logic                               last_result
);

	msps_pkg::cmd_t  cmd;
	msps_pkg::stat_t stat;

	msps_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	msps_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.point_value   (point_value),
		.row_index     (row_index),
		.col_index     (col_index),
		.last_result   (last_result)
	);

endmodule
